FILE: sv/scof_pkg.sv
package scof_pkg;

    // field widths
    localparam int COORD_W    = 24;
    localparam int RAD_W      = 52;
    localparam int CWID_W     = 23;
    localparam int LVL_W      = 3;
    localparam int CLASS_W    = 2;
    localparam int COUNT_W    = 13;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 52;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_CENTER_X  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_Z  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RADIUS_SQ = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CELL_W    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_LEVEL     = 3'd5;

    // register reset values
    localparam logic [RAD_W-1:0]  RADIUS_SQ_RST = 52'd16777216;
    localparam logic [CWID_W-1:0] CELL_W_RST    = 23'd4096;
    localparam logic [LVL_W-1:0]  LEVEL_RST     = 3'd2;

    // overlap classes
    localparam logic [CLASS_W-1:0] CLASS_ENCLOSED = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_PARTIAL  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NONE     = 2'd2;

    // largest count the result word carries
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

    // which point enters the distance pipeline
    typedef enum logic [1:0] {
        PT_FAR  = 2'd0,
        PT_NEAR = 2'd1,
        PT_SUB  = 2'd2
    } pt_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    axes;
        logic    issue;
        pt_sel_t sel;
        logic    step;
        logic    finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic pipe_empty;
    } status_t;

endpackage

FILE: sv/sphere_cell_overlap_fraction.sv
// Sphere against cubic cell overlap, counted by subcell centres.
// Configuration: cfg_we with cfg_index and cfg_data writes one register at the
// clock edge (centre x/y/z, squared radius, cell width, subsample level).
// Write registers only while busy is low and no result is pending.
// Input: a word (left_x, left_y, left_z) is taken at an edge with start high
// and busy low. busy stays high until the result is produced.
// Output: done is high for one cycle with overlap_class and enclosed_count;
// the receiver takes it at once, there is no back pressure.
// Operation: after start is taken, the single squared-distance pipeline tests
// one point per cycle: the furthest point, the nearest point and every subcell
// centre go through it, and the result appears once it has drained. The next
// word can be taken in the cycle in which done is high.
// Reset: the registers return to centre 0, radius 1.0, cell width 1.0,
// level 2, and the block is idle with done low.
module sphere_cell_overlap_fraction
    import scof_pkg::*;
#(
    parameter int MAX_SUBSAMPLE = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] left_x,
    input  logic signed [COORD_W-1:0] left_y,
    input  logic signed [COORD_W-1:0] left_z,
    output logic                      done,
    output logic [CLASS_W-1:0]        overlap_class,
    output logic [COUNT_W-1:0]        enclosed_count
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    scof_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // registers, walk and distance pipeline
    scof_dp #(
        .MAX_SUBSAMPLE (MAX_SUBSAMPLE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .left_x         (left_x),
        .left_y         (left_y),
        .left_z         (left_z),
        .cmd            (cmd),
        .status         (status),
        .done           (done),
        .overlap_class  (overlap_class),
        .enclosed_count (enclosed_count)
    );

endmodule

FILE: sv/scof_ctrl.sv
module scof_ctrl
    import scof_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_AXES  = 6'b000010,
        ST_FAR   = 6'b000100,
        ST_NEAR  = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_DRAIN = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = PT_SUB;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_AXES;
                end
            end
            ST_AXES:
            begin
                cmd.axes   = 1'b1;
                state_next = ST_FAR;
            end
            ST_FAR:
            begin
                cmd.issue  = 1'b1;
                cmd.sel    = PT_FAR;
                state_next = ST_NEAR;
            end
            ST_NEAR:
            begin
                cmd.issue  = 1'b1;
                cmd.sel    = PT_NEAR;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                cmd.sel   = PT_SUB;
                cmd.step  = !status.sweep_last;
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: sv/scof_dp.sv
module scof_dp
    import scof_pkg::*;
#(
    parameter int MAX_SUBSAMPLE = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [COORD_W-1:0] left_x,
    input  logic signed [COORD_W-1:0] left_y,
    input  logic signed [COORD_W-1:0] left_z,
    input  cmd_t                      cmd,
    output status_t                   status,
    output logic                      done,
    output logic [CLASS_W-1:0]        overlap_class,
    output logic [COUNT_W-1:0]        enclosed_count
);

    localparam int SMAX   = MAX_SUBSAMPLE + 1;
    localparam int CRD_W  = COORD_W + SMAX + 1;
    localparam int DIF_W  = CRD_W;
    localparam int SQ_W   = 2 * DIF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int LIM_W  = RAD_W + 2 * SMAX;
    localparam int CMP_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;
    localparam int IW     = SMAX;
    localparam int CNT_W  = 3 * MAX_SUBSAMPLE + 1;
    localparam int CNT_X  = (CNT_W > COUNT_W + 1) ? CNT_W : COUNT_W + 1;

    typedef struct packed {
        logic signed [CRD_W-1:0] near;
        logic signed [CRD_W-1:0] far;
    } axis_t;

    // nearest and furthest point on one axis, ties go to the upper face
    function automatic axis_t axis_pts(input logic signed [CRD_W-1:0] c,
                                       input logic signed [CRD_W-1:0] l,
                                       input logic signed [CRD_W-1:0] r);
        axis_t                 a;
        logic signed [CRD_W:0] twice_c;
        logic signed [CRD_W:0] l_plus_r;
        twice_c  = {c, 1'b0};
        l_plus_r = {l[CRD_W-1], l} + {r[CRD_W-1], r};
        if (c <= l)
        begin
            a.near = l;
            a.far  = r;
        end
        else if (c >= r)
        begin
            a.near = r;
            a.far  = l;
        end
        else
        begin
            a.near = c;
            a.far  = (twice_c > l_plus_r) ? l : r;
        end
        return a;
    endfunction

    function automatic logic [DIF_W-1:0] abs_diff(input logic signed [CRD_W-1:0] p,
                                                  input logic signed [CRD_W-1:0] c);
        logic signed [CRD_W:0] d;
        d = {p[CRD_W-1], p} - {c[CRD_W-1], c};
        return d[CRD_W] ? DIF_W'(-d) : DIF_W'(d);
    endfunction

    // configuration registers
    logic signed [COORD_W-1:0] cx_cfg_reg;
    logic signed [COORD_W-1:0] cy_cfg_reg;
    logic signed [COORD_W-1:0] cz_cfg_reg;
    logic [RAD_W-1:0]          rad_cfg_reg;
    logic [CWID_W-1:0]         cw_cfg_reg;
    logic [LVL_W-1:0]          lvl_cfg_reg;

    // per item scaled values
    logic [LVL_W-1:0]        n_reg;
    logic [IW-1:0]           mmax_reg;
    logic signed [CRD_W-1:0] lx_reg, ly_reg, lz_reg;
    logic signed [CRD_W-1:0] cwk_reg;
    logic signed [CRD_W-1:0] cxs_reg, cys_reg, czs_reg;
    logic [LIM_W-1:0]        lim_reg;

    // classification points and subcell walk
    logic signed [CRD_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [CRD_W-1:0] fx_reg, fy_reg, fz_reg;
    logic signed [CRD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [CRD_W-1:0] bx_reg, by_reg, bz_reg;
    logic [IW-1:0]           ix_reg, iy_reg, iz_reg;

    // distance pipeline
    logic                    v1_reg, v2_reg;
    pt_sel_t                 tag1_reg, tag2_reg;
    logic [DIF_W-1:0]        dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;

    // accumulated results
    logic                    far_in_reg, near_in_reg;
    logic [CNT_W-1:0]        count_reg;

    // result word
    logic                    done_reg;
    logic [CLASS_W-1:0]      class_reg;
    logic [COUNT_W-1:0]      count_out_reg;

    logic [LVL_W-1:0]        n_eff;
    logic [LVL_W-1:0]        s_eff;
    logic signed [CRD_W-1:0] cw_ext, cw2;
    axis_t                   ax, ay, az;
    logic signed [CRD_W-1:0] sel_x, sel_y, sel_z;
    logic [SUM_W-1:0]        dist_sum;
    logic                    pt_hit;
    logic [CNT_X-1:0]        full_cnt, part_cnt;
    logic [CLASS_W-1:0]      class_next;
    logic [CNT_X-1:0]        cnt_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_cfg_reg  <= '0;
            cy_cfg_reg  <= '0;
            cz_cfg_reg  <= '0;
            rad_cfg_reg <= RADIUS_SQ_RST;
            cw_cfg_reg  <= CELL_W_RST;
            lvl_cfg_reg <= LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:  cx_cfg_reg  <= cfg_data[COORD_W-1:0];
                CFG_CENTER_Y:  cy_cfg_reg  <= cfg_data[COORD_W-1:0];
                CFG_CENTER_Z:  cz_cfg_reg  <= cfg_data[COORD_W-1:0];
                CFG_RADIUS_SQ: rad_cfg_reg <= cfg_data[RAD_W-1:0];
                CFG_CELL_W:    cw_cfg_reg  <= cfg_data[CWID_W-1:0];
                CFG_LEVEL:     lvl_cfg_reg <= cfg_data[LVL_W-1:0];
                default:       ;
            endcase
        end
    end

    // effective level and scale shift
    assign n_eff = (lvl_cfg_reg > LVL_W'(MAX_SUBSAMPLE)) ? LVL_W'(MAX_SUBSAMPLE)
                                                         : lvl_cfg_reg;
    assign s_eff = n_eff + LVL_W'(1);

    assign cw_ext = CRD_W'(cw_cfg_reg);
    assign cw2    = {cw_ext[CRD_W-2:0], 1'b0};

    assign ax = axis_pts(cxs_reg, lx_reg, lx_reg + cwk_reg);
    assign ay = axis_pts(cys_reg, ly_reg, ly_reg + cwk_reg);
    assign az = axis_pts(czs_reg, lz_reg, lz_reg + cwk_reg);

    // item setup, axis points and subcell walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= n_eff;
            mmax_reg <= (IW'(1) << n_eff) - IW'(1);
            lx_reg   <= CRD_W'(left_x) << s_eff;
            ly_reg   <= CRD_W'(left_y) << s_eff;
            lz_reg   <= CRD_W'(left_z) << s_eff;
            cwk_reg  <= CRD_W'(cw_cfg_reg) << s_eff;
            cxs_reg  <= CRD_W'(cx_cfg_reg) << s_eff;
            cys_reg  <= CRD_W'(cy_cfg_reg) << s_eff;
            czs_reg  <= CRD_W'(cz_cfg_reg) << s_eff;
            lim_reg  <= LIM_W'(rad_cfg_reg) << {s_eff, 1'b0};
        end
        if (cmd.axes)
        begin
            nx_reg <= ax.near;
            ny_reg <= ay.near;
            nz_reg <= az.near;
            fx_reg <= ax.far;
            fy_reg <= ay.far;
            fz_reg <= az.far;
            px_reg <= lx_reg + cw_ext;
            py_reg <= ly_reg + cw_ext;
            pz_reg <= lz_reg + cw_ext;
            bx_reg <= lx_reg + cw_ext;
            by_reg <= ly_reg + cw_ext;
            bz_reg <= lz_reg + cw_ext;
            ix_reg <= '0;
            iy_reg <= '0;
            iz_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (ix_reg != mmax_reg)
            begin
                ix_reg <= ix_reg + IW'(1);
                px_reg <= px_reg + cw2;
            end
            else
            begin
                ix_reg <= '0;
                px_reg <= bx_reg;
                if (iy_reg != mmax_reg)
                begin
                    iy_reg <= iy_reg + IW'(1);
                    py_reg <= py_reg + cw2;
                end
                else
                begin
                    iy_reg <= '0;
                    py_reg <= by_reg;
                    iz_reg <= iz_reg + IW'(1);
                    pz_reg <= pz_reg + cw2;
                end
            end
        end
    end

    // point selection for the distance pipeline
    always_comb
    begin
        case (cmd.sel)
            PT_FAR:
            begin
                sel_x = fx_reg;
                sel_y = fy_reg;
                sel_z = fz_reg;
            end
            PT_NEAR:
            begin
                sel_x = nx_reg;
                sel_y = ny_reg;
                sel_z = nz_reg;
            end
            default:
            begin
                sel_x = px_reg;
                sel_y = py_reg;
                sel_z = pz_reg;
            end
        endcase
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            done_reg <= cmd.finish;
        end
    end

    // stage one: axis distances, stage two: squares
    always_ff @(posedge clk)
    begin
        tag1_reg <= cmd.sel;
        dx_reg   <= abs_diff(sel_x, cxs_reg);
        dy_reg   <= abs_diff(sel_y, cys_reg);
        dz_reg   <= abs_diff(sel_z, czs_reg);
        tag2_reg <= tag1_reg;
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        sqz_reg  <= dz_reg * dz_reg;
    end

    // stage three: sum and compare against the scaled radius
    assign dist_sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    assign pt_hit   = (CMP_W'(dist_sum) <= CMP_W'(lim_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.axes)
        begin
            count_reg   <= '0;
            far_in_reg  <= 1'b0;
            near_in_reg <= 1'b0;
        end
        else if (v2_reg)
        begin
            case (tag2_reg)
                PT_FAR:  far_in_reg  <= pt_hit;
                PT_NEAR: near_in_reg <= pt_hit;
                default: count_reg   <= count_reg + CNT_W'(pt_hit);
            endcase
        end
    end

    // classification and saturated count
    assign full_cnt = CNT_X'(1) << (5'(n_reg) * 5'd3);
    assign part_cnt = CNT_X'(count_reg);

    always_comb
    begin
        if (far_in_reg)
        begin
            class_next = CLASS_ENCLOSED;
            cnt_next   = full_cnt;
        end
        else if (!near_in_reg)
        begin
            class_next = CLASS_NONE;
            cnt_next   = '0;
        end
        else
        begin
            class_next = CLASS_PARTIAL;
            cnt_next   = part_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            class_reg     <= class_next;
            count_out_reg <= (cnt_next > CNT_X'(COUNT_MAX)) ? COUNT_MAX
                                                             : cnt_next[COUNT_W-1:0];
        end
    end

    assign status.sweep_last = (ix_reg == mmax_reg) && (iy_reg == mmax_reg)
                               && (iz_reg == mmax_reg);
    assign status.pipe_empty = !v1_reg && !v2_reg;

    assign done           = done_reg;
    assign overlap_class  = class_reg;
    assign enclosed_count = count_out_reg;

endmodule
